// ===== hdl/lirs_pkg.sv =====
// ----------------------------------------------------------------------------
// lirs_pkg - shared types and constants for the linear interpolation resampler
// Holds the controller state type, the command and status bundles between
// controller and datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package lirs_pkg;

    localparam int SAMPLE_W = 16;   // audio sample width
    localparam int POS_W    = 20;   // time position / step width

    localparam logic [POS_W-1:0] STEP_RESET = 20'd32768;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch incoming sample
        logic prime;    // first sample: fill the store
        logic skip;     // no output this interval, drop one sample of time
        logic start;    // open a run of outputs
        logic mul;      // difference times phase, next position
        logic add;      // round and clamp into output register
        logic next;     // advance to next output of the run
        logic finish;   // close the run, update position and held sample
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic primed;
        logic pos_lt_one;   // stored position lies inside current interval
        logic last;         // output now in flight ends the run
    } t_status;

endpackage

// ===== hdl/lirs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lirs_ctrl - sequencer of the linear interpolation resampler
// Walks each input beat through priming, skipping or a run of outputs and
// drives the datapath through command strobes.
// ----------------------------------------------------------------------------
module lirs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lirs_pkg::t_status i_status,
    output lirs_pkg::t_cmd    o_cmd
);

    lirs_pkg::t_state r_state;
    lirs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lirs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lirs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lirs_pkg::ST_DECIDE;
                end
            end
            lirs_pkg::ST_DECIDE: begin
                if (!i_status.primed || !i_status.pos_lt_one) begin
                    n_state = lirs_pkg::ST_IDLE;
                end else begin
                    n_state = lirs_pkg::ST_MUL;
                end
            end
            lirs_pkg::ST_MUL: begin
                n_state = lirs_pkg::ST_ADD;
            end
            lirs_pkg::ST_ADD: begin
                n_state = lirs_pkg::ST_OUT;
            end
            lirs_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_status.last ? lirs_pkg::ST_IDLE : lirs_pkg::ST_MUL;
                end
            end
            default: begin
                n_state = lirs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            lirs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            lirs_pkg::ST_DECIDE: begin
                o_cmd.prime = !i_status.primed;
                o_cmd.skip  = i_status.primed && !i_status.pos_lt_one;
                o_cmd.start = i_status.primed && i_status.pos_lt_one;
            end
            lirs_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            lirs_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
            end
            lirs_pkg::ST_OUT: begin
                o_out_valid  = 1'b1;
                o_cmd.finish = i_out_ready && i_status.last;
                o_cmd.next   = i_out_ready && !i_status.last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_ready_xor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_in_ready, o_out_valid}))
        else $error("input ready while a result is offered");

    a_end_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_status.last) |=> o_in_ready)
        else $error("input not reopened after end of run");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.prime, o_cmd.skip, o_cmd.start, o_cmd.finish, o_cmd.next}))
        else $error("conflicting datapath commands");

endmodule

// ===== hdl/lirs_dp.sv =====
// ----------------------------------------------------------------------------
// lirs_dp - datapath of the linear interpolation resampler
// Step register, held sample, time position, phase multiplier, rounding and
// clamping, output register.
// ----------------------------------------------------------------------------
module lirs_dp #(
    parameter int PHASE_BITS   = 15,
    parameter int MAX_UPSAMPLE = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lirs_pkg::POS_W-1:0]           i_cfg_wdata,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_in,
    input  lirs_pkg::t_cmd                       i_cmd,
    output lirs_pkg::t_status                    o_status,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_run_end
);

    localparam int PW     = lirs_pkg::POS_W;
    localparam int SW     = lirs_pkg::SAMPLE_W;
    localparam int DIFF_W = SW + 1;
    localparam int PROD_W = DIFF_W + PHASE_BITS + 1;
    localparam int V_W    = PHASE_BITS + SW + 3;
    localparam int Q_W    = V_W - PHASE_BITS;
    localparam int CNT_W  = $clog2(MAX_UPSAMPLE + 1);
    localparam int HALF   = 1 << (PHASE_BITS - 1);
    localparam logic [PW:0]      ONE      = (PW+1)'(1) << PHASE_BITS;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_UPSAMPLE - 1);

    logic [PW-1:0]           r_step;
    logic [PW-1:0]           r_pos;
    logic                    r_primed;
    logic signed [SW-1:0]    r_held;
    logic signed [SW-1:0]    r_new;
    logic [PW-1:0]           r_t;
    logic [PW-1:0]           r_tn;
    logic                    r_tge;
    logic [CNT_W-1:0]        r_n;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_last;
    logic signed [SW-1:0]    r_y;

    logic signed [DIFF_W-1:0]       diff;
    logic signed [PHASE_BITS:0]     frac_s;
    logic signed [PROD_W-1:0]       prod;
    logic [PW:0]                    t_sum;
    logic [PW-1:0]                  t_next;
    logic                           t_next_ge;
    logic signed [V_W-1:0]          v;
    logic signed [Q_W-1:0]          q;
    logic signed [SW-1:0]           y;

    // blend = held + (new - held) * f, done as one product
    assign diff   = DIFF_W'(r_new) - DIFF_W'(r_held);
    assign frac_s = $signed({1'b0, r_t[PHASE_BITS-1:0]});
    assign prod   = diff * frac_s;

    // next position, saturating at the top of the 20-bit range
    assign t_sum     = {1'b0, r_t} + {1'b0, r_step};
    assign t_next    = t_sum[PW] ? {PW{1'b1}} : t_sum[PW-1:0];
    assign t_next_ge = ({1'b0, t_next} >= ONE);

    // round half up, floor shift, clamp
    assign v = (V_W'(r_held) <<< PHASE_BITS) + V_W'(r_prod) + V_W'(HALF);
    assign q = $signed(v[V_W-1:PHASE_BITS]);
    always_comb begin
        if (q > Q_W'(lirs_pkg::SAMPLE_MAX)) begin
            y = lirs_pkg::SAMPLE_MAX;
        end else if (q < Q_W'(lirs_pkg::SAMPLE_MIN)) begin
            y = lirs_pkg::SAMPLE_MIN;
        end else begin
            y = q[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= lirs_pkg::STEP_RESET;
            r_pos    <= '0;
            r_primed <= 1'b0;
            r_held   <= '0;
            r_n      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_cmd.prime) begin
                r_held   <= r_new;
                r_primed <= 1'b1;
            end
            if (i_cmd.skip) begin
                r_pos  <= PW'({1'b0, r_pos} - ONE);
                r_held <= r_new;
            end
            if (i_cmd.start) begin
                r_n <= '0;
            end
            if (i_cmd.next) begin
                r_n <= r_n + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_pos  <= r_tge ? PW'({1'b0, r_tn} - ONE) : '0;
                r_held <= r_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new <= i_sample_in;
        end
        if (i_cmd.start) begin
            r_t <= r_pos;
        end
        if (i_cmd.next) begin
            r_t <= r_tn;
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
            r_tn   <= t_next;
            r_tge  <= t_next_ge;
            r_last <= t_next_ge || (r_n == CNT_LAST);
        end
        if (i_cmd.add) begin
            r_y <= y;
        end
    end

    assign o_status.primed     = r_primed;
    assign o_status.pos_lt_one = ({1'b0, r_pos} < ONE);
    assign o_status.last       = r_last;
    assign o_sample_out        = r_y;
    assign o_run_end           = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_LAST)
        else $error("output count past the per-input limit");

    a_limit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_tge) |-> (r_n == CNT_LAST))
        else $error("run cut short inside the interval below the limit");

    a_prime_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> r_primed)
        else $error("output run started before priming");

endmodule

// ===== hdl/linear_interp_resampler_core.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_core - linear interpolation sample rate converter
// Takes one signed 16-bit sample per input beat and emits the output samples
// that fall before it, each a rounded, clamped blend of the two neighbors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  i_in_valid / o_in_ready carries i_sample_in.
//   Output channel o_out_valid / i_out_ready carries o_sample_out and
//   o_run_end, which marks the last output beat caused by an input beat.
//   i_cfg_we / i_cfg_wdata write the output period (Q PHASE_BITS input
//   samples); write it only while the block is idle.
// Sequencing:
//   One input beat is worked at a time. The first beat after reset only
//   fills the held sample; a beat that yields no output only moves the
//   position and held sample on. Otherwise each output passes through the
//   loop multiply, round/clamp, present, and the next one starts only
//   after the previous one is taken.
//   At most MAX_UPSAMPLE outputs follow one input; the input side reopens
//   the cycle after the output beat flagged with o_run_end is taken.
// Reset (synchronous, active low) clears position, held sample and the
// primed flag and loads the default step of one input sample. A stalled
// receiver simply holds the current output beat; nothing is lost.
// ----------------------------------------------------------------------------
module linear_interp_resampler_core #(
    parameter int PHASE_BITS   = 15,
    parameter int MAX_UPSAMPLE = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [lirs_pkg::POS_W-1:0]           i_cfg_wdata,
    // input beats
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_in,
    // output beats
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_run_end
);

    lirs_pkg::t_cmd    cmd;
    lirs_pkg::t_status status;

    // sequencer: one state per step of the output loop
    lirs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath: state, multiplier, rounding, output register
    lirs_dp #(
        .PHASE_BITS   (PHASE_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_sample_in),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_sample_out (o_sample_out),
        .o_run_end    (o_run_end)
    );

endmodule

// ===== sim/lirs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lirs_checker - output predictor and scoreboard for the resampler core
// Watches the config, input and output channels, predicts every output beat
// from the accepted input beats and compares the beats in order.
// ----------------------------------------------------------------------------
module lirs_checker #(
    parameter int PHASE_BITS   = 15,
    parameter int MAX_UPSAMPLE = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lirs_pkg::POS_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_out,
    input  logic                                 i_run_end,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    localparam int POS_W    = lirs_pkg::POS_W;
    localparam int SAMPLE_W = lirs_pkg::SAMPLE_W;

    localparam longint ONE     = longint'(1) << PHASE_BITS;
    localparam longint POS_MAX = (longint'(1) << POS_W) - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       run_end;
    } t_out_beat;

    t_out_beat expected_outs[$];
    t_out_beat want;

    logic [POS_W-1:0]           step_q;
    logic [POS_W-1:0]           pos_q;
    logic signed [SAMPLE_W-1:0] held_q;
    logic                       primed_q;

    int fails   = 0;
    int pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    // weighted blend of two neighbors, round half up, clamp to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] blend(input longint a, input longint b,
                                                         input longint f);
        longint v;
        v = a * (ONE - f) + b * f + ONE / 2;
        v = v >>> PHASE_BITS;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic predict_outputs(input logic signed [SAMPLE_W-1:0] x);
        longint    t;
        int        n;
        logic      more;
        t_out_beat b;
        if (!primed_q) begin
            held_q   = x;
            primed_q = 1'b1;
            return;
        end
        t    = longint'(pos_q);
        n    = 0;
        more = (t < ONE);
        while (more) begin
            b.sample = blend(held_q, x, t % ONE);
            n++;
            t = t + longint'(step_q);
            if (t > POS_MAX) t = POS_MAX;
            more      = (t < ONE) && (n < MAX_UPSAMPLE);
            b.run_end = !more;
            expected_outs.push_back(b);
        end
        // cap hit inside the interval drops the rest and restarts at zero
        pos_q  = (t >= ONE) ? POS_W'(t - ONE) : '0;
        held_q = x;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_q   = lirs_pkg::STEP_RESET;
            pos_q    = '0;
            held_q   = '0;
            primed_q = 1'b0;
            expected_outs.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_outputs(i_sample_in);
            if (i_out_valid && i_out_ready) begin
                if (expected_outs.size() == 0) begin
                    $error("unexpected output beat: sample_out %0d run_end %0b",
                           i_sample_out, i_run_end);
                    fails++;
                end else begin
                    want = expected_outs.pop_front();
                    if (i_sample_out !== want.sample) begin
                        $error("sample_out: expected %0d, got %0d", want.sample, i_sample_out);
                        fails++;
                    end
                    if (i_run_end !== want.run_end) begin
                        $error("run_end: expected %0b, got %0b", want.run_end, i_run_end);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) step_q = i_cfg_wdata;
        end
        pending = expected_outs.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for linear_interp_resampler_core
// Drives sample beats and step settings, stalls both channels at random and
// leaves prediction and checking to lirs_checker; prints the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int POS_W    = lirs_pkg::POS_W;
    localparam int SAMPLE_W = lirs_pkg::SAMPLE_W;

    localparam int IDLE_PCT    = 37;    // chance of an idle cycle per side
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 37;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [POS_W-1:0]           i_cfg_wdata = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_run_end;

    int   fail_count;
    int   pending;
    logic calm = 1'b0;      // no idling on either side while set

    linear_interp_resampler_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_run_end    (o_run_end)
    );

    lirs_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sample_out (o_sample_out),
        .i_run_end    (o_run_end),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: ready is redrawn every falling edge, so stalls land on the
    // first beat of a run, inside it and on the beat that ends it.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Hard stop: well above the slowest legal run (every beat of a run
    // behind a stalled receiver, every input paying the sender's gaps).
    initial begin
        #8_000_000;
        $display("** linear_interp_resampler_core: FAILED **");
        $finish;
    end

    // One input beat. Called and returning at a falling edge; valid is
    // assigned once per falling edge, either low for a gap or high with data.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted beat has arrived. A beat that
    // only primes or yields nothing keeps the core busy with nothing
    // pending, hence the extra wait after pending reaches zero.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Step writes happen only with the core idle.
    task automatic set_step(input logic [POS_W-1:0] step);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= step;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly full-range noise; also rails and small moves around the last
    // value so the blends cover both extreme and smooth neighbors.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        input logic signed [SAMPLE_W-1:0] prev);
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(9))
            0:       s = lirs_pkg::SAMPLE_MAX;
            1:       s = lirs_pkg::SAMPLE_MIN;
            2, 3:    s = prev + SAMPLE_W'($urandom_range(0, 512)) - 16'sd256;
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    initial begin
        logic signed [SAMPLE_W-1:0] last;
        logic [POS_W-1:0]           step;

        last = '0;

        // ---------------------------------------------------------------
        // reset, held from time zero and then released
        // ---------------------------------------------------------------
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---------------------------------------------------------------
        // Directed. At the reset step (one output per input) the first beat
        // only primes the held sample; then rails and sign boundaries.
        // ---------------------------------------------------------------
        push_sample(lirs_pkg::SAMPLE_MAX);
        push_sample(lirs_pkg::SAMPLE_MIN);
        push_sample(lirs_pkg::SAMPLE_MAX);
        push_sample(16'sd0);
        push_sample(-16'sd1);

        // half-phase blends between opposite rails: rounding at the edges
        set_step(POS_W'(16384));
        push_sample(lirs_pkg::SAMPLE_MIN);
        push_sample(lirs_pkg::SAMPLE_MAX);
        push_sample(lirs_pkg::SAMPLE_MIN);
        push_sample(16'sd1);

        // zero step: position never advances, the upsample cap closes each
        // run and the position restarts at zero
        set_step('0);
        push_sample(lirs_pkg::SAMPLE_MAX);
        push_sample(lirs_pkg::SAMPLE_MIN);

        // largest step: position saturates, later inputs yield nothing
        set_step('1);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        push_sample(lirs_pkg::SAMPLE_MAX);
        push_sample(lirs_pkg::SAMPLE_MIN);

        // range extremes: 16x down, then exactly 64 outputs per input
        set_step(POS_W'(524288));
        push_sample(lirs_pkg::SAMPLE_MIN);
        push_sample(lirs_pkg::SAMPLE_MAX);
        push_sample(16'sd0);
        set_step(POS_W'(512));
        push_sample(lirs_pkg::SAMPLE_MAX);
        push_sample(lirs_pkg::SAMPLE_MIN);

        // odd fractional step just under the cap
        set_step(POS_W'(513));
        push_sample(16'sd12345);
        push_sample(-16'sd12345);

        // ---------------------------------------------------------------
        // Random. One step per phase; the first phase runs with no idling
        // on either side. Every phase starts after a full drain.
        // ---------------------------------------------------------------
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       step = POS_W'(16384);
                1:       step = POS_W'($urandom_range(4096, 32768));
                2:       step = POS_W'(512);
                3:       step = POS_W'(524288);
                4:       step = POS_W'($urandom_range(32768, 131072));
                5:       step = POS_W'(1);
                6:       step = POS_W'($urandom_range(512, 524288));
                7:       step = '1;
                8:       step = POS_W'(24576);
                9:       step = POS_W'($urandom_range(8192, 65536));
                default: step = lirs_pkg::STEP_RESET;
            endcase
            set_step(step);
            calm = (p == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                last = pick_sample(last);
                push_sample(last);
            end
            calm = 1'b0;
        end

        // ---------------------------------------------------------------
        // wind down and verdict
        // ---------------------------------------------------------------
        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("** linear_interp_resampler_core: PASSED **");
        else
            $display("** linear_interp_resampler_core: FAILED **");
        $finish;
    end

endmodule
